// ----- sv/sacld_pkg.sv -----
// Shared constants and types of the cache LRU directory.
`timescale 1ns / 1ps
`default_nettype none

package sacld_pkg;

  // Default geometry of the directory
  localparam int NUM_SETS_DEF    = 64;
  localparam int NUM_WAYS_DEF    = 4;
  localparam int BLOCK_BYTES_DEF = 64;
  localparam int ADDR_BITS_DEF   = 32;

  // Width of the running access counters
  localparam int CNT_BITS = 32;

  // Access kinds carried by in_action
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Sequencer states: clear sweep, wait for a beat, look up and update
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

endpackage

`default_nettype wire

// ----- sv/sacld_ram.sv -----
// Set row memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sacld_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one row
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one row; hold the data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/sacld_set_update.sv -----
// Tag compare, victim choice and rank/dirty update of one set row.
`timescale 1ns / 1ps
`default_nettype none

module sacld_set_update #(
  parameter int NUM_WAYS  = 4,
  parameter int TAG_BITS  = 20,
  parameter int WAY_BITS  = 2,
  parameter int RANK_BITS = 3
) (
  input  wire logic                               is_write,
  input  wire logic [TAG_BITS-1:0]                tag,
  input  wire logic [NUM_WAYS-1:0][TAG_BITS-1:0]  row_tag,
  input  wire logic [NUM_WAYS-1:0][RANK_BITS-1:0] row_rank,
  input  wire logic [NUM_WAYS-1:0]                row_dirty,
  input  wire logic [RANK_BITS-1:0]               row_filled,
  output logic                                    hit,
  output logic      [WAY_BITS-1:0]                way,
  output logic                                    writeback,
  output logic      [TAG_BITS-1:0]                victim_tag,
  output logic      [NUM_WAYS-1:0][TAG_BITS-1:0]  new_tag,
  output logic      [NUM_WAYS-1:0][RANK_BITS-1:0] new_rank,
  output logic      [NUM_WAYS-1:0]                new_dirty,
  output logic      [RANK_BITS-1:0]               new_filled
);

  localparam logic [RANK_BITS-1:0] RANK_LAST  = RANK_BITS'(NUM_WAYS);
  localparam logic [RANK_BITS-1:0] RANK_FIRST = RANK_BITS'(1);

  logic                 full;
  logic [WAY_BITS-1:0]  hit_way;
  logic                 lru_found;
  logic [WAY_BITS-1:0]  lru_way;
  logic [RANK_BITS-1:0] touch_rank;

  // Compare the tag in the filled ways; first match wins
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (!hit && (RANK_BITS'(i) < row_filled) && (row_tag[i] == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(i);
      end
    end
  end

  // Pick the way ranked least recent, way 0 when none carries that rank
  always_comb begin
    lru_found = 1'b0;
    lru_way   = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (!lru_found && (row_rank[i] == RANK_LAST)) begin
        lru_found = 1'b1;
        lru_way   = WAY_BITS'(i);
      end
    end
  end

  // Choose the way: hit way, else next free way, else the victim
  always_comb begin
    full = (row_filled >= RANK_LAST);
    if (hit) begin
      way = hit_way;
    end else if (!full) begin
      way = row_filled[WAY_BITS-1:0];
    end else begin
      way = lru_way;
    end
    new_filled = (!hit && !full) ? row_filled + RANK_FIRST : row_filled;
    writeback  = !hit && full && row_dirty[lru_way];
    victim_tag = row_tag[lru_way];
  end

  // Install the tag on a miss and update the dirty bit
  always_comb begin
    new_tag = row_tag;
    if (!hit) begin
      new_tag[way] = tag;
    end
    new_dirty      = row_dirty;
    new_dirty[way] = is_write | (hit & row_dirty[way]);
  end

  // Age the filled ways that were more recent than the touched one
  always_comb begin
    touch_rank = row_rank[way];
    for (int i = 0; i < NUM_WAYS; i++) begin
      if ((RANK_BITS'(i) < new_filled) && (row_rank[i] < touch_rank)) begin
        new_rank[i] = row_rank[i] + RANK_FIRST;
      end else begin
        new_rank[i] = row_rank[i];
      end
    end
    new_rank[way] = RANK_FIRST;
  end

endmodule

`default_nettype wire

// ----- sv/set_assoc_cache_lru_directory.sv -----
// Top level of the write-back cache tag, dirty and LRU directory.
// Each set is one row of a synchronous memory that holds the tags, LRU ranks
// and dirty bits of all ways plus the count of filled ways. An access runs in two
// steps: the beat is taken and its set row read, then the row is compared,
// updated and written back while the result is loaded into the output
// register; that step waits while a pending result is stalled. A new access is
// taken only after the previous one has been written back, since the row memory
// is updated by read-modify-write. After reset the block sweeps the memory, one
// row a cycle, and holds in_stall high meanwhile. NUM_SETS and BLOCK_BYTES are
// powers of two. The counters count reads, read misses, writes and write misses
// including the access shown and wrap at 32 bits.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_lru_directory #(
  parameter int NUM_SETS    = sacld_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS    = sacld_pkg::NUM_WAYS_DEF,
  parameter int BLOCK_BYTES = sacld_pkg::BLOCK_BYTES_DEF,
  parameter int ADDR_BITS   = sacld_pkg::ADDR_BITS_DEF,
  localparam int OFF_BITS   = $clog2(BLOCK_BYTES),
  localparam int SET_BITS   = $clog2(NUM_SETS),
  localparam int WAY_BITS   = $clog2(NUM_WAYS),
  localparam int BLK_BITS   = ADDR_BITS - OFF_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_action,
  input  wire logic [ADDR_BITS-1:0]           in_address,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_hit,
  output logic      [SET_BITS-1:0]            out_set_index,
  output logic      [WAY_BITS-1:0]            out_way_index,
  output logic                                out_fill,
  output logic                                out_writeback,
  output logic      [BLK_BITS-1:0]            out_victim_block,
  output logic      [OFF_BITS-1:0]            out_byte_offset,
  output logic      [sacld_pkg::CNT_BITS-1:0] out_read_count,
  output logic      [sacld_pkg::CNT_BITS-1:0] out_read_miss_count,
  output logic      [sacld_pkg::CNT_BITS-1:0] out_write_count,
  output logic      [sacld_pkg::CNT_BITS-1:0] out_write_miss_count
);

  localparam int RANK_BITS = $clog2(NUM_WAYS + 1);
  localparam int TAG_BITS  = BLK_BITS - SET_BITS;
  localparam int ROW_BITS  = NUM_WAYS * (TAG_BITS + RANK_BITS + 1) + RANK_BITS;
  localparam int CNT_BITS  = sacld_pkg::CNT_BITS;
  localparam logic [SET_BITS-1:0] SET_LAST = SET_BITS'(NUM_SETS - 1);

  sacld_pkg::state_t state_r, state_nxt;

  logic [SET_BITS-1:0]  clr_idx_r;
  logic                 act_r;
  logic [ADDR_BITS-1:0] addr_r;

  logic                 in_take;
  logic                 out_free;
  logic                 done;

  logic                 ram_we;
  logic [SET_BITS-1:0]  ram_waddr;
  logic [ROW_BITS-1:0]  ram_wdata;
  logic [ROW_BITS-1:0]  ram_rdata;
  logic [ROW_BITS-1:0]  clear_row;
  logic [ROW_BITS-1:0]  upd_row;

  logic [TAG_BITS-1:0]                cur_tag;
  logic [SET_BITS-1:0]                cur_set;
  logic [NUM_WAYS-1:0][TAG_BITS-1:0]  row_tag;
  logic [NUM_WAYS-1:0][RANK_BITS-1:0] row_rank;
  logic [NUM_WAYS-1:0]                row_dirty;
  logic [RANK_BITS-1:0]               row_filled;
  logic [NUM_WAYS-1:0][TAG_BITS-1:0]  clr_tag;
  logic [NUM_WAYS-1:0][RANK_BITS-1:0] clr_rank;

  logic                               upd_hit;
  logic [WAY_BITS-1:0]                upd_way;
  logic                               upd_wb;
  logic [TAG_BITS-1:0]                upd_victim_tag;
  logic [NUM_WAYS-1:0][TAG_BITS-1:0]  upd_tag;
  logic [NUM_WAYS-1:0][RANK_BITS-1:0] upd_rank;
  logic [NUM_WAYS-1:0]                upd_dirty;
  logic [RANK_BITS-1:0]               upd_filled;

  logic                out_valid_r;
  logic                out_hit_r;
  logic [SET_BITS-1:0] out_set_r;
  logic [WAY_BITS-1:0] out_way_r;
  logic                out_wb_r;
  logic [BLK_BITS-1:0] out_victim_r;
  logic [OFF_BITS-1:0] out_off_r;
  logic [CNT_BITS-1:0] rd_cnt_r;
  logic [CNT_BITS-1:0] rd_miss_cnt_r;
  logic [CNT_BITS-1:0] wr_cnt_r;
  logic [CNT_BITS-1:0] wr_miss_cnt_r;

  // Handshake
  assign in_stall = (state_r != sacld_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign done     = (state_r == sacld_pkg::ST_LOOK) && out_free;

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacld_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sacld_pkg::ST_CLEAR: begin
        if (clr_idx_r == SET_LAST) begin
          state_nxt = sacld_pkg::ST_IDLE;
        end
      end
      sacld_pkg::ST_IDLE: begin
        if (in_take) begin
          state_nxt = sacld_pkg::ST_LOOK;
        end
      end
      sacld_pkg::ST_LOOK: begin
        if (out_free) begin
          state_nxt = sacld_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sacld_pkg::ST_CLEAR;
    endcase
  end

  // Advance the clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (state_r == sacld_pkg::ST_CLEAR) begin
      clr_idx_r <= clr_idx_r + SET_BITS'(1);
    end
  end

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (in_take) begin
      act_r  <= in_action;
      addr_r <= in_address;
    end
  end

  assign cur_tag = addr_r[ADDR_BITS-1 -: TAG_BITS];
  assign cur_set = addr_r[OFF_BITS +: SET_BITS];

  // Reset contents of a row: ranks at the way count, nothing filled or dirty
  always_comb begin
    for (int i = 0; i < NUM_WAYS; i++) begin
      clr_tag[i]  = '0;
      clr_rank[i] = RANK_BITS'(NUM_WAYS);
    end
    clear_row = {RANK_BITS'(0), NUM_WAYS'(0), clr_rank, clr_tag};
  end

  assign {row_filled, row_dirty, row_rank, row_tag} = ram_rdata;
  assign upd_row = {upd_filled, upd_dirty, upd_rank, upd_tag};

  // Write port: clear sweep, then row write-back
  always_comb begin
    if (state_r == sacld_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = clear_row;
    end else begin
      ram_we    = done;
      ram_waddr = cur_set;
      ram_wdata = upd_row;
    end
  end

  sacld_ram #(
    .DEPTH  (NUM_SETS),
    .WIDTH  (ROW_BITS),
    .ADDR_W (SET_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_take),
    .raddr (in_address[OFF_BITS +: SET_BITS]),
    .rdata (ram_rdata)
  );

  sacld_set_update #(
    .NUM_WAYS  (NUM_WAYS),
    .TAG_BITS  (TAG_BITS),
    .WAY_BITS  (WAY_BITS),
    .RANK_BITS (RANK_BITS)
  ) u_update (
    .is_write   (act_r == sacld_pkg::ACT_WRITE),
    .tag        (cur_tag),
    .row_tag    (row_tag),
    .row_rank   (row_rank),
    .row_dirty  (row_dirty),
    .row_filled (row_filled),
    .hit        (upd_hit),
    .way        (upd_way),
    .writeback  (upd_wb),
    .victim_tag (upd_victim_tag),
    .new_tag    (upd_tag),
    .new_rank   (upd_rank),
    .new_dirty  (upd_dirty),
    .new_filled (upd_filled)
  );

  // Output valid: set on a finished lookup, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (done) begin
      out_hit_r    <= upd_hit;
      out_set_r    <= cur_set;
      out_way_r    <= upd_way;
      out_wb_r     <= upd_wb;
      out_victim_r <= upd_wb ? {upd_victim_tag, cur_set} : '0;
      out_off_r    <= addr_r[OFF_BITS-1:0];
    end
  end

  // Advance the access and miss counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r      <= '0;
      rd_miss_cnt_r <= '0;
      wr_cnt_r      <= '0;
      wr_miss_cnt_r <= '0;
    end else if (done) begin
      if (act_r == sacld_pkg::ACT_WRITE) begin
        wr_cnt_r <= wr_cnt_r + CNT_BITS'(1);
        if (!upd_hit) begin
          wr_miss_cnt_r <= wr_miss_cnt_r + CNT_BITS'(1);
        end
      end else begin
        rd_cnt_r <= rd_cnt_r + CNT_BITS'(1);
        if (!upd_hit) begin
          rd_miss_cnt_r <= rd_miss_cnt_r + CNT_BITS'(1);
        end
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit              = out_hit_r;
  assign out_set_index        = out_set_r;
  assign out_way_index        = out_way_r;
  assign out_fill             = !out_hit_r;
  assign out_writeback        = out_wb_r;
  assign out_victim_block     = out_victim_r;
  assign out_byte_offset      = out_off_r;
  assign out_read_count       = rd_cnt_r;
  assign out_read_miss_count  = rd_miss_cnt_r;
  assign out_write_count      = wr_cnt_r;
  assign out_write_miss_count = wr_miss_cnt_r;

  // A beat is taken only once the clear sweep is over
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sacld_pkg::ST_CLEAR) |-> !in_take)
    else $error("input beat taken during clear sweep");

  // A finished lookup returns to idle
  a_look_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (state_r == sacld_pkg::ST_IDLE))
    else $error("lookup did not return to idle");

  // A writeback only comes with a fill
  a_wb_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_writeback) |-> out_fill)
    else $error("writeback without fill");

  // Counters move only when a result is loaded
  a_cnt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !done |=> ($stable(rd_cnt_r) && $stable(wr_cnt_r)))
    else $error("access counter moved without a result");

  // A pending result holds while stalled
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_way_r)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
